@@ rtl/core/ffla_pkg.sv @@
// Shared types, widths and constants of the fixed block free list allocator.
// No dependencies; every other file of the block but ffla_ram refers to it by scoped names.
package ffla_pkg;

  localparam int IDX_W           = 10;
  localparam int CFG_W           = 11;
  localparam int APB_DATA_W      = 32;
  localparam int APB_ADDR_W      = 3;
  localparam int POOL_BLOCKS_DEF = 1024;

  localparam logic [CFG_W-1:0] BPR_RST  = 11'd4;
  localparam logic [CFG_W-1:0] MAXR_RST = 11'd256;
  localparam logic [CFG_W-1:0] CFG_MIN  = 11'd1;
  localparam logic [CFG_W-1:0] CFG_MAX  = 11'd1024;

  typedef enum logic {
    REG_BPR  = 1'b0,
    REG_MAXR = 1'b1
  } reg_idx_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_POP  = 1'b1
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] granted;
    status_t          status;
    logic             opened;
  } result_t;

  function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_MIN;
    end else if (v > CFG_MAX) begin
      r = CFG_MAX;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/fixed_block_free_list_allocator_top.sv @@
// Top level of the fixed block free list allocator: APB registers and instances.
// Depends on ffla_pkg, ffla_ram, ffla_out_q and ffla_ctrl.
//
//   channel  dir  handshake                    word
//   in_      in   in_valid / in_ready          in_operation, in_block_index
//   out_     out  out_valid / out_ready        out_granted_index, out_status,
//                                              out_opened_region
//   cfg      in   psel/penable/pwrite, pready  paddr, pwdata, prdata
//
// A free or a bump-pointer allocate pushes its result in the cycle it is accepted;
// an allocate popped from the free list pushes it from S_POP, after the registered read of the link RAM.
// Reset is synchronous: list empty, bump pointer zero, one region open;
// the link RAM is not cleared and needs no sweep.
// Input stalls while the two-word result queue is full and while the controller
// is in S_POP for a pop.
module fixed_block_free_list_allocator_top #(
  parameter int POOL_BLOCKS = ffla_pkg::POOL_BLOCKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_operation,
  input  logic [ffla_pkg::IDX_W-1:0]      in_block_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ffla_pkg::IDX_W-1:0]      out_granted_index,
  output logic [1:0]                      out_status,
  output logic                            out_opened_region,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ffla_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ffla_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ffla_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int IW = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;

  logic [ffla_pkg::CFG_W-1:0] bpr_r, bpr_nxt;
  logic [ffla_pkg::CFG_W-1:0] maxr_r, maxr_nxt;
  logic                       cfg_wr;
  ffla_pkg::reg_idx_t         cfg_sel;

  logic              q_full, push;
  ffla_pkg::result_t push_word, out_word;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = ffla_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    bpr_nxt  = bpr_r;
    maxr_nxt = maxr_r;
    if (cfg_wr) begin
      case (cfg_sel)
        ffla_pkg::REG_BPR:  bpr_nxt  = pwdata[ffla_pkg::CFG_W-1:0];
        ffla_pkg::REG_MAXR: maxr_nxt = pwdata[ffla_pkg::CFG_W-1:0];
        default:            bpr_nxt  = bpr_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      ffla_pkg::REG_BPR:  prdata = ffla_pkg::APB_DATA_W'(bpr_r);
      ffla_pkg::REG_MAXR: prdata = ffla_pkg::APB_DATA_W'(maxr_r);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpr_r  <= ffla_pkg::BPR_RST;
      maxr_r <= ffla_pkg::MAXR_RST;
    end else begin
      bpr_r  <= bpr_nxt;
      maxr_r <= maxr_nxt;
    end
  end

  ffla_ctrl #(
    .POOL_BLOCKS(POOL_BLOCKS),
    .IW         (IW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_block_index   (in_block_index),
    .blocks_per_region(bpr_r),
    .max_regions      (maxr_r),
    .q_full           (q_full),
    .push             (push),
    .push_word        (push_word),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata)
  );

  ffla_ram #(
    .DATA_W(IW),
    .DEPTH (POOL_BLOCKS),
    .AW    (IW)
  ) u_link_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ffla_out_q u_out_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_word(push_word),
    .full     (q_full),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  assign out_granted_index = out_word.granted;
  assign out_status        = out_word.status;
  assign out_opened_region = out_word.opened;

endmodule

@@ rtl/core/ffla_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ffla_ram #(
  parameter int DATA_W = 10,
  parameter int DEPTH  = 1024,
  parameter int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ffla_out_q.sv @@
// Two-word result queue between the allocator core and the output channel.
// Depends on ffla_pkg for the result word type.
module ffla_out_q (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ffla_pkg::result_t push_word,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output ffla_pkg::result_t out_word
);

  ffla_pkg::result_t q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign out_word  = q_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

@@ rtl/core/ffla_ctrl.sv @@
// Allocator control: free list head, bump pointer, region count, link RAM access.
// Depends on ffla_pkg; drives ffla_ram and ffla_out_q through the top level.
module ffla_ctrl #(
  parameter int POOL_BLOCKS = ffla_pkg::POOL_BLOCKS_DEF,
  parameter int IW = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_operation,
  input  logic [ffla_pkg::IDX_W-1:0] in_block_index,
  input  logic [ffla_pkg::CFG_W-1:0] blocks_per_region,
  input  logic [ffla_pkg::CFG_W-1:0] max_regions,
  input  logic                       q_full,
  output logic                       push,
  output ffla_pkg::result_t          push_word,
  output logic                       ram_we,
  output logic [IW-1:0]              ram_waddr,
  output logic [IW-1:0]              ram_wdata,
  output logic [IW-1:0]              ram_raddr,
  input  logic [IW-1:0]              ram_rdata
);

  localparam int BW = $clog2(POOL_BLOCKS + 1);
  localparam int CW = (BW > ffla_pkg::IDX_W) ? BW : ffla_pkg::IDX_W;
  localparam int PW = 2 * ffla_pkg::CFG_W;

  ffla_pkg::state_t           state_r, state_nxt;
  logic [IW-1:0]              head_r, head_nxt;
  logic                       nonempty_r, nonempty_nxt;
  logic [BW-1:0]              bump_r, bump_nxt;
  logic [ffla_pkg::CFG_W-1:0] ro_r, ro_nxt;

  logic                       accept;
  logic [ffla_pkg::CFG_W-1:0] bpr, maxr;
  logic [PW-1:0]              region_limit;
  logic [IW-1:0]              idx_iw;

  assign in_ready     = (state_r == ffla_pkg::S_IDLE) && !q_full;
  assign accept       = in_valid && in_ready;
  assign bpr          = ffla_pkg::clamp_cfg(blocks_per_region);
  assign maxr         = ffla_pkg::clamp_cfg(max_regions);
  assign region_limit = PW'(ro_r) * PW'(bpr);
  assign idx_iw       = IW'(in_block_index);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffla_pkg::S_IDLE: begin
        if (accept && (in_operation == ffla_pkg::OP_ALLOC) && nonempty_r) begin
          state_nxt = ffla_pkg::S_POP;
        end
      end
      ffla_pkg::S_POP: begin
        state_nxt = ffla_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ffla_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    head_nxt         = head_r;
    nonempty_nxt     = nonempty_r;
    bump_nxt         = bump_r;
    ro_nxt           = ro_r;
    push             = 1'b0;
    push_word        = '0;
    push_word.status = ffla_pkg::ST_OK;
    ram_we           = 1'b0;
    ram_waddr        = idx_iw;
    ram_wdata        = nonempty_r ? head_r : idx_iw;
    ram_raddr        = head_r;
    case (state_r)
      ffla_pkg::S_IDLE: begin
        if (accept) begin
          if (in_operation == ffla_pkg::OP_FREE) begin
            push = 1'b1;
            if (CW'(in_block_index) >= CW'(bump_r)) begin
              push_word.status = ffla_pkg::ST_BADFREE;
            end else begin
              ram_we       = 1'b1;
              head_nxt     = idx_iw;
              nonempty_nxt = 1'b1;
            end
          end else if (!nonempty_r) begin
            push = 1'b1;
            if (bump_r == BW'(POOL_BLOCKS)) begin
              push_word.status = ffla_pkg::ST_OOM;
            end else if (PW'(bump_r) < region_limit) begin
              push_word.granted = ffla_pkg::IDX_W'(bump_r);
              bump_nxt          = bump_r + BW'(1);
            end else if (ro_r < maxr) begin
              push_word.granted = ffla_pkg::IDX_W'(bump_r);
              push_word.opened  = 1'b1;
              bump_nxt          = bump_r + BW'(1);
              ro_nxt            = ro_r + ffla_pkg::CFG_W'(1);
            end else begin
              push_word.status = ffla_pkg::ST_OOM;
            end
          end
        end
      end
      ffla_pkg::S_POP: begin
        push              = 1'b1;
        push_word.granted = ffla_pkg::IDX_W'(head_r);
        if (ram_rdata == head_r) begin
          nonempty_nxt = 1'b0;
        end else begin
          head_nxt = ram_rdata;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ffla_pkg::S_IDLE;
      head_r     <= '0;
      nonempty_r <= 1'b0;
      bump_r     <= '0;
      ro_r       <= ffla_pkg::CFG_W'(1);
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      nonempty_r <= nonempty_nxt;
      bump_r     <= bump_nxt;
      ro_r       <= ro_nxt;
    end
  end

endmodule
